/* design/ljf_pkg.sv */
// Shared types and constants for the longest-job-first dispatcher.
// Used by ljf_seq and longest_job_first_dispatcher_unit; depends on nothing.
`default_nettype none

package ljf_pkg;

    localparam int DEF_MAX_JOBS    = 16;
    localparam int DEF_LENGTH_BITS = 16;
    localparam int ID_W            = 8;
    localparam int LEN_PORT_W      = 16;
    localparam int WAIT_W          = 16;
    localparam int COUNT_OUT_W     = 5;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic                   dispatched;
        logic [ID_W-1:0]        dispatched_id;
        logic [WAIT_W-1:0]      dispatched_wait;
        logic                   busy_res;
        logic                   dropped;
        logic [COUNT_OUT_W-1:0] ready_count;
    } result_t;

endpackage

`default_nettype wire

/* design/ljf_ram.sv */
// Single-port-write, single-port-read job store with registered read data.
// Generic memory; depends on nothing.
`default_nettype none

module ljf_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/ljf_seq.sv */
// Sequencer that sweeps the job store: arrivals, dispatch, compaction and wait update.
// Depends on ljf_pkg; drives one ljf_ram instance owned by the top level.
`default_nettype none

module ljf_seq #(
    parameter int MAX_JOBS    = ljf_pkg::DEF_MAX_JOBS,
    parameter int LENGTH_BITS = ljf_pkg::DEF_LENGTH_BITS,
    localparam int IDX_W      = $clog2(MAX_JOBS),
    localparam int CNT_W      = $clog2(MAX_JOBS + 1),
    localparam int ENTRY_W    = ljf_pkg::ID_W + LENGTH_BITS + ljf_pkg::WAIT_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          command,
    input  wire logic [ljf_pkg::ID_W-1:0]      job_id,
    input  wire logic [ljf_pkg::LEN_PORT_W-1:0] job_length,
    output logic                               res_valid,
    output ljf_pkg::result_t                   res,
    input  wire logic                          res_take,
    output logic                               wr_en,
    output logic [IDX_W-1:0]                   wr_addr,
    output logic [ENTRY_W-1:0]                 wr_data,
    output logic                               rd_en,
    output logic [IDX_W-1:0]                   rd_addr,
    input  wire logic [ENTRY_W-1:0]            rd_data
);

    localparam int WAIT_W = ljf_pkg::WAIT_W;
    localparam int ID_W   = ljf_pkg::ID_W;

    ljf_pkg::seq_state_t state_reg, state_next;

    logic [CNT_W-1:0]       n_reg, n_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [LENGTH_BITS-1:0] best_len_reg, best_len_next;
    logic [CNT_W-1:0]       rptr_reg, rptr_next;
    logic                   pv_reg, pv_next;
    logic [IDX_W-1:0]       pidx_reg, pidx_next;
    logic                   acc_found_reg, acc_found_next;
    logic [IDX_W-1:0]       acc_idx_reg, acc_idx_next;
    logic [LENGTH_BITS-1:0] acc_len_reg, acc_len_next;
    logic                   disp_reg, disp_next;
    logic [ID_W-1:0]        did_reg, did_next;
    logic [WAIT_W-1:0]      dwait_reg, dwait_next;
    logic                   drop_reg, drop_next;

    logic [31:0]            len_wide;
    logic [LENGTH_BITS-1:0] len_mask;
    logic [LENGTH_BITS-1:0] len_fix;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [ID_W-1:0]        e_id;
    logic [LENGTH_BITS-1:0] e_len;
    logic [WAIT_W-1:0]      e_wait;
    logic [WAIT_W-1:0]      e_wait_inc;
    logic [IDX_W-1:0]       new_pos;
    logic                   last_entry;
    logic [31:0]            n_wide;

    assign len_wide   = 32'(job_length);
    assign len_mask   = len_wide[LENGTH_BITS-1:0];
    assign len_fix    = (len_mask == '0) ? LENGTH_BITS'(1) : len_mask;
    assign rem_dec    = rem_reg - LENGTH_BITS'(rem_reg != '0);

    assign e_id       = rd_data[ENTRY_W-1 -: ID_W];
    assign e_len      = rd_data[WAIT_W +: LENGTH_BITS];
    assign e_wait     = rd_data[WAIT_W-1:0];
    assign e_wait_inc = (e_wait == ljf_pkg::WAIT_MAX) ? e_wait : e_wait + WAIT_W'(1);
    assign new_pos    = (disp_reg && (pidx_reg > best_idx_reg)) ? pidx_reg - IDX_W'(1)
                                                                : pidx_reg;
    assign last_entry = pv_reg && ((CNT_W'(pidx_reg) + CNT_W'(1)) == n_reg);

    assign n_wide              = 32'(n_reg);
    assign res.dispatched      = disp_reg;
    assign res.dispatched_id   = did_reg;
    assign res.dispatched_wait = dwait_reg;
    assign res.busy_res        = (rem_reg != '0);
    assign res.dropped         = drop_reg;
    assign res.ready_count     = n_wide[ljf_pkg::COUNT_OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ljf_pkg::S_IDLE;
            n_reg         <= '0;
            rem_reg       <= '0;
            best_idx_reg  <= '0;
            best_len_reg  <= '0;
            rptr_reg      <= '0;
            pv_reg        <= 1'b0;
            pidx_reg      <= '0;
            acc_found_reg <= 1'b0;
            acc_idx_reg   <= '0;
            acc_len_reg   <= '0;
            disp_reg      <= 1'b0;
            did_reg       <= '0;
            dwait_reg     <= '0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            rem_reg       <= rem_next;
            best_idx_reg  <= best_idx_next;
            best_len_reg  <= best_len_next;
            rptr_reg      <= rptr_next;
            pv_reg        <= pv_next;
            pidx_reg      <= pidx_next;
            acc_found_reg <= acc_found_next;
            acc_idx_reg   <= acc_idx_next;
            acc_len_reg   <= acc_len_next;
            disp_reg      <= disp_next;
            did_reg       <= did_next;
            dwait_reg     <= dwait_next;
            drop_reg      <= drop_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        best_idx_next  = best_idx_reg;
        best_len_next  = best_len_reg;
        rptr_next      = rptr_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        acc_found_next = acc_found_reg;
        acc_idx_next   = acc_idx_reg;
        acc_len_next   = acc_len_reg;
        disp_next      = disp_reg;
        did_next       = did_reg;
        dwait_next     = dwait_reg;
        drop_next      = drop_reg;
        in_stall       = 1'b1;
        res_valid      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            ljf_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    disp_next  = 1'b0;
                    did_next   = '0;
                    dwait_next = '0;
                    drop_next  = 1'b0;
                    state_next = ljf_pkg::S_DONE;
                    if (command == ljf_pkg::CMD_ARRIVAL)
                    begin
                        if (n_reg == CNT_W'(MAX_JOBS))
                        begin
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = n_reg[IDX_W-1:0];
                            wr_data = {job_id, len_fix, WAIT_W'(0)};
                            n_next  = n_reg + CNT_W'(1);
                            if ((n_reg == '0) || (len_fix >= best_len_reg))
                            begin
                                best_idx_next = n_reg[IDX_W-1:0];
                                best_len_next = len_fix;
                            end
                        end
                    end
                    else
                    begin
                        rem_next = rem_dec;
                        if (n_reg != '0)
                        begin
                            disp_next      = (rem_dec == '0);
                            rptr_next      = '0;
                            pv_next        = 1'b0;
                            acc_found_next = 1'b0;
                            state_next     = ljf_pkg::S_UPDATE;
                        end
                    end
                end
            end

            ljf_pkg::S_UPDATE:
            begin
                if (rptr_reg < n_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = rptr_reg[IDX_W-1:0];
                    rptr_next = rptr_reg + CNT_W'(1);
                    pv_next   = 1'b1;
                    pidx_next = rptr_reg[IDX_W-1:0];
                end
                else
                begin
                    pv_next = 1'b0;
                end

                if (pv_reg)
                begin
                    if (disp_reg && (pidx_reg == best_idx_reg))
                    begin
                        did_next   = e_id;
                        dwait_next = e_wait;
                        rem_next   = e_len;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = new_pos;
                        wr_data = {e_id, e_len, e_wait_inc};
                        if (!acc_found_reg || (e_len >= acc_len_reg))
                        begin
                            acc_found_next = 1'b1;
                            acc_idx_next   = new_pos;
                            acc_len_next   = e_len;
                        end
                    end
                end

                if (last_entry)
                begin
                    n_next        = n_reg - CNT_W'(disp_reg);
                    best_idx_next = acc_idx_next;
                    best_len_next = acc_len_next;
                    pv_next       = 1'b0;
                    state_next    = ljf_pkg::S_DONE;
                end
            end

            ljf_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ljf_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ljf_pkg::S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(MAX_JOBS))
    else $error("ready count exceeds list depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.dispatched) |-> res.busy_res)
    else $error("dispatched job does not leave the server busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.dropped) |-> (n_reg == CNT_W'(MAX_JOBS) && !res.dispatched))
    else $error("drop reported while the list has room");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ljf_pkg::S_IDLE && n_reg != '0) |-> (CNT_W'(best_idx_reg) < n_reg))
    else $error("cached longest job lies outside the list");

endmodule

`default_nettype wire

/* design/longest_job_first_dispatcher_unit.sv */
// Top level of the longest-job-first dispatcher: sequencer, job store and output register.
// Depends on ljf_pkg, ljf_ram and ljf_seq.
//
//   Channel | Signals                                  | Direction
//   input   | in_valid, in_stall, command, job_id, ... | item in, stall out
//   output  | out_valid, out_stall, dispatched, ...    | item out, stall in
//
// An arrival, and a tick with an empty list, go straight to the result; a tick with ready jobs
// makes one sweep over the job store through its single read port.
// Reset clears the count and the server; the job store needs no clearing.
// The input stalls while an item is being worked on or its result cannot enter the output register.
`default_nettype none

module longest_job_first_dispatcher_unit #(
    parameter int MAX_JOBS    = ljf_pkg::DEF_MAX_JOBS,
    parameter int LENGTH_BITS = ljf_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            command,
    input  wire logic [ljf_pkg::ID_W-1:0]        job_id,
    input  wire logic [ljf_pkg::LEN_PORT_W-1:0]  job_length,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 dispatched,
    output logic [ljf_pkg::ID_W-1:0]             dispatched_id,
    output logic [ljf_pkg::WAIT_W-1:0]           dispatched_wait,
    output logic                                 busy_res,
    output logic                                 dropped,
    output logic [ljf_pkg::COUNT_OUT_W-1:0]      ready_count
);

    localparam int IDX_W   = $clog2(MAX_JOBS);
    localparam int ENTRY_W = ljf_pkg::ID_W + LENGTH_BITS + ljf_pkg::WAIT_W;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic             res_valid;
    logic             res_take;
    ljf_pkg::result_t res;

    logic             out_valid_reg, out_valid_next;
    ljf_pkg::result_t out_reg;

    ljf_ram #(
        .DEPTH (MAX_JOBS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ljf_seq #(
        .MAX_JOBS    (MAX_JOBS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .job_id     (job_id),
        .job_length (job_length),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign dispatched      = out_reg.dispatched;
    assign dispatched_id   = out_reg.dispatched_id;
    assign dispatched_wait = out_reg.dispatched_wait;
    assign busy_res        = out_reg.busy_res;
    assign dropped         = out_reg.dropped;
    assign ready_count     = out_reg.ready_count;

endmodule

`default_nettype wire

/* verif/tb_longest_job_first_dispatcher_unit.sv */
// Self-checking testbench for longest_job_first_dispatcher_unit: a queued driver, a monitor and
// an in-bench scheduler model that predicts every result. Depends on ljf_pkg and the design.
module tb_longest_job_first_dispatcher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_READY    = ljf_pkg::DEF_MAX_JOBS;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int RANDOM_ITEMS = 780;
    localparam int ID_W         = ljf_pkg::ID_W;
    localparam int LEN_PORT_W   = ljf_pkg::LEN_PORT_W;
    localparam int WAIT_W       = ljf_pkg::WAIT_W;
    localparam int COUNT_OUT_W  = ljf_pkg::COUNT_OUT_W;

    typedef struct {
        logic                  command;
        logic [ID_W-1:0]       job_id;
        logic [LEN_PORT_W-1:0] job_length;
    } job_item_t;

    typedef struct {
        logic [ID_W-1:0]       id;
        logic [LEN_PORT_W-1:0] len;
        logic [WAIT_W-1:0]     waited;
    } ready_job_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic command = ljf_pkg::CMD_ARRIVAL;
    logic [ID_W-1:0] job_id = '0;
    logic [LEN_PORT_W-1:0] job_length = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic dispatched;
    logic [ID_W-1:0] dispatched_id;
    logic [WAIT_W-1:0] dispatched_wait;
    logic busy_res;
    logic dropped;
    logic [COUNT_OUT_W-1:0] ready_count;

    job_item_t job_items[$];
    job_item_t next_item;
    ljf_pkg::result_t expected_results[$];
    ljf_pkg::result_t oldest_result;
    ready_job_t ready_list[$];
    logic [LEN_PORT_W-1:0] service_left = '0;
    logic calm = 1'b0;
    int failures = 0;
    int cycles = 0;

    longest_job_first_dispatcher_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .job_id          (job_id),
        .job_length      (job_length),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .dispatched      (dispatched),
        .dispatched_id   (dispatched_id),
        .dispatched_wait (dispatched_wait),
        .busy_res        (busy_res),
        .dropped         (dropped),
        .ready_count     (ready_count)
    );

    always #6 clk = ~clk;

    function automatic ljf_pkg::result_t schedule_job(logic cmd, logic [ID_W-1:0] id,
                                                      logic [LEN_PORT_W-1:0] len);
        ljf_pkg::result_t res;
        ready_job_t job;
        int best;
        res = '0;
        if (cmd == ljf_pkg::CMD_ARRIVAL)
        begin
            if (ready_list.size() >= MAX_READY)
            begin
                res.dropped = 1'b1;
            end
            else
            begin
                job.id = id;
                job.len = (len == '0) ? LEN_PORT_W'(1) : len;
                job.waited = '0;
                ready_list.push_back(job);
            end
        end
        else
        begin
            if (service_left != '0)
            begin
                service_left = service_left - 1'b1;
            end
            if (service_left == '0 && ready_list.size() > 0)
            begin
                best = 0;
                for (int i = 1; i < ready_list.size(); i++)
                begin
                    if (ready_list[i].len >= ready_list[best].len)
                    begin
                        best = i;
                    end
                end
                res.dispatched = 1'b1;
                res.dispatched_id = ready_list[best].id;
                res.dispatched_wait = ready_list[best].waited;
                service_left = ready_list[best].len;
                ready_list.delete(best);
            end
            for (int i = 0; i < ready_list.size(); i++)
            begin
                if (ready_list[i].waited != ljf_pkg::WAIT_MAX)
                begin
                    ready_list[i].waited = ready_list[i].waited + 1'b1;
                end
            end
        end
        res.busy_res = (service_left != '0);
        res.ready_count = COUNT_OUT_W'(ready_list.size());
        return res;
    endfunction

    task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            failures++;
        end
    endtask

    task automatic push_arrival(logic [ID_W-1:0] id, logic [LEN_PORT_W-1:0] len);
        job_item_t it;
        it.command = ljf_pkg::CMD_ARRIVAL;
        it.job_id = id;
        it.job_length = len;
        job_items.push_back(it);
    endtask

    task automatic push_tick();
        job_item_t it;
        it.command = ljf_pkg::CMD_TICK;
        it.job_id = ID_W'($urandom);
        it.job_length = LEN_PORT_W'($urandom);
        job_items.push_back(it);
    endtask

    function automatic logic [LEN_PORT_W-1:0] pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
        begin
            return LEN_PORT_W'($urandom_range(0, 6));
        end
        return LEN_PORT_W'($urandom_range(7, 30));
    endfunction

    task automatic wait_drained();
        while (job_items.size() > 0 || in_valid || expected_results.size() > 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(schedule_job(command, job_id, job_length));
            end
            if (!in_valid || !in_stall)
            begin
                if (job_items.size() > 0 && (calm || $urandom_range(99) >= 6))
                begin
                    next_item = job_items.pop_front();
                    in_valid <= 1'b1;
                    command <= next_item.command;
                    job_id <= next_item.job_id;
                    job_length <= next_item.job_length;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result arrived with no item outstanding");
                    failures++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    check_field("dispatched", oldest_result.dispatched, dispatched);
                    check_field("dispatched_id", oldest_result.dispatched_id, dispatched_id);
                    check_field("dispatched_wait", oldest_result.dispatched_wait,
                                dispatched_wait);
                    check_field("busy_res", oldest_result.busy_res, busy_res);
                    check_field("dropped", oldest_result.dropped, dropped);
                    check_field("ready_count", oldest_result.ready_count, ready_count);
                end
            end
            out_stall <= !calm && ($urandom_range(99) < 6);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int burst;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_tick();
        push_arrival(8'h00, 16'h0000);
        push_tick();
        push_tick();
        push_arrival(8'hFF, 16'd3);
        push_arrival(8'hAA, 16'd3);
        push_arrival(8'h55, 16'd2);
        push_tick();
        for (int i = 0; i < 14; i++)
        begin
            push_arrival(ID_W'($urandom), LEN_PORT_W'($urandom_range(1, 4)));
        end
        push_arrival(8'h81, 16'd7);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 20)
            begin
                burst = $urandom_range(4, 18);
                for (int i = 0; i < burst; i++)
                begin
                    push_arrival(ID_W'($urandom), pick_length());
                end
            end
            else
            begin
                burst = $urandom_range(5, 25);
                for (int i = 0; i < burst; i++)
                begin
                    if ($urandom_range(99) < 40)
                    begin
                        push_arrival(ID_W'($urandom), pick_length());
                    end
                    else
                    begin
                        push_tick();
                    end
                end
            end
            sent += burst;
        end
        wait_drained();

        while (ready_list.size() > 0 || service_left != '0)
        begin
            push_tick();
            wait_drained();
        end

        calm = 1'b1;
        push_arrival(8'hC3, 16'd40);
        push_arrival(8'h3C, 16'd5);
        push_arrival(8'h96, 16'd2);
        for (int i = 0; i < 50; i++)
        begin
            push_tick();
        end
        wait_drained();
        calm = 1'b0;

        repeat (40) @(posedge clk);
        if (failures == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
